// File: rtl/nearest_match_distance_macros.svh
// ----------------------------------------------------------------------------
// nearest_match_distance_macros
// Assertion macros used by the datapath RTL of the nearest-match distance block.
// ----------------------------------------------------------------------------
`ifndef NEAREST_MATCH_DISTANCE_MACROS_SVH
`define NEAREST_MATCH_DISTANCE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define NMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nmd assertion failed");
// next-cycle implication
`define NMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nmd assertion failed");
`else
`define NMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/nmd_pkg.sv
// ----------------------------------------------------------------------------
// nmd_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package nmd_pkg;

    localparam int MAX_LEN_DEF = 64;

    // controller to datapath
    typedef struct packed {
        logic take;       // input beat taken
        logic take_last;  // input beat taken and it ends the string
        logic back;       // backward pass step
        logic prime;      // prime read of entry 0
        logic emit;       // result emission
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic ptr_zero;   // backward pass at entry 0
        logic emit_done;  // last result beat leaving
    } t_sts;

endpackage

// File: rtl/nmd_ram.sv
// ----------------------------------------------------------------------------
// nmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/nmd_ctrl.sv
// ----------------------------------------------------------------------------
// nmd_ctrl
// Sequencer: load, backward pass, emission.
// ----------------------------------------------------------------------------
module nmd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_final_byte,
    output logic          o_in_stall,
    output nmd_pkg::t_cmd o_cmd,
    input  nmd_pkg::t_sts i_sts
);

    import nmd_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_BREAD = 5'b00010,
        S_BACK  = 5'b00100,
        S_PRIME = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign take = i_in_valid && (r_state == S_LOAD);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (take && i_final_byte) begin
                    n_state = S_BREAD;
                end
            end
            S_BREAD: begin
                n_state = S_BACK;
            end
            S_BACK: begin
                if (i_sts.ptr_zero) begin
                    n_state = S_PRIME;
                end
            end
            S_PRIME: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.emit_done) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall      = (r_state != S_LOAD);
    assign o_cmd.take      = take;
    assign o_cmd.take_last = take && i_final_byte;
    assign o_cmd.back      = (r_state == S_BACK);
    assign o_cmd.prime     = (r_state == S_PRIME);
    assign o_cmd.emit      = (r_state == S_EMIT);

endmodule

// File: rtl/nmd_dp.sv
// ----------------------------------------------------------------------------
// nmd_dp
// Datapath: forward distance on load, backward min pass, result register.
// ----------------------------------------------------------------------------
`include "nearest_match_distance_macros.svh"

module nmd_dp #(
    parameter int MAX_LEN = nmd_pkg::MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [7:0]                   i_cfg_wr_data,
    input  logic [7:0]                   i_text_byte,
    input  nmd_pkg::t_cmd                i_cmd,
    output nmd_pkg::t_sts                o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [$clog2(MAX_LEN+1)-1:0] o_distance,
    output logic                         o_no_target,
    output logic                         o_truncated,
    output logic                         o_last_result
);

    import nmd_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int DW = $clog2(MAX_LEN + 1);
    localparam logic [DW-1:0] DMAX = DW'(MAX_LEN);

    function automatic logic [DW-1:0] sat_inc(input logic [DW-1:0] v);
        return (v >= DMAX) ? DMAX : v + DW'(1);
    endfunction

    logic [7:0]    r_target;
    logic [DW-1:0] r_count;
    logic [DW-1:0] r_prev;
    logic          r_any;
    logic          r_ovf;
    logic          r_no_target_l;
    logic          r_trunc_l;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;
    logic [AW-1:0] r_last_idx;
    logic [DW-1:0] r_back;
    logic          r_emit_all;
    logic          r_out_valid;
    logic [DW-1:0] r_out_dist;
    logic          r_out_no_target;
    logic          r_out_trunc;
    logic          r_out_last;

    logic          stored;
    logic          match;
    logic [DW-1:0] fwd_new;
    logic [DW-1:0] rdata;
    logic [DW-1:0] back_new;
    logic [DW-1:0] dmin;
    logic          out_free;
    logic          out_load;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;

    assign stored   = (r_count < DMAX);
    assign match    = (i_text_byte == r_target);
    assign fwd_new  = match ? '0 : ((r_count == '0) ? DMAX : sat_inc(r_prev));
    assign back_new = (rdata == '0) ? '0 : sat_inc(r_back);
    assign dmin     = (back_new < rdata) ? back_new : rdata;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = i_cmd.emit && out_free && !r_emit_all;

    always_comb begin
        ram_we    = i_cmd.take && stored;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = fwd_new;
        if (i_cmd.back) begin
            ram_we    = 1'b1;
            ram_waddr = r_ptr;
            ram_wdata = dmin;
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.take_last) begin
            n_ptr = stored ? r_count[AW-1:0] : AW'(MAX_LEN - 1);
        end else if (i_cmd.back) begin
            n_ptr = r_ptr - AW'(1);
        end else if (i_cmd.prime) begin
            n_ptr = '0;
        end else if (out_load) begin
            n_ptr = r_ptr + AW'(1);
        end
    end

    nmd_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_LEN)
    ) u_fwd_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_ptr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_count     <= '0;
            r_any       <= 1'b0;
            r_ovf       <= 1'b0;
            r_emit_all  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            if (i_cmd.take_last) begin
                r_count <= '0;
                r_any   <= 1'b0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.take) begin
                if (stored) begin
                    r_count <= r_count + DW'(1);
                    r_any   <= r_any | match;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.prime) begin
                r_emit_all <= 1'b0;
            end else if (out_load && (r_ptr == r_last_idx)) begin
                r_emit_all <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.take && stored) begin
            r_prev <= fwd_new;
        end
        if (i_cmd.take_last) begin
            r_last_idx    <= stored ? r_count[AW-1:0] : AW'(MAX_LEN - 1);
            r_no_target_l <= !(r_any || (stored && match));
            r_trunc_l     <= r_ovf || !stored;
            r_back        <= DMAX;
        end else if (i_cmd.back) begin
            r_back <= back_new;
        end
        if (out_load) begin
            r_out_dist      <= rdata;
            r_out_no_target <= r_no_target_l;
            r_out_trunc     <= r_trunc_l;
            r_out_last      <= (r_ptr == r_last_idx);
        end
    end

    assign o_sts.ptr_zero  = (r_ptr == '0);
    assign o_sts.emit_done = r_emit_all && out_free;

    assign o_out_valid   = r_out_valid;
    assign o_distance    = r_out_dist;
    assign o_no_target   = r_out_no_target;
    assign o_truncated   = r_out_trunc;
    assign o_last_result = r_out_last;

    `NMD_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= DMAX)
    `NMD_ASSERT_IMP(a_no_target_sat, i_clk, i_rst_n, r_out_valid && r_out_no_target,
                    r_out_dist == DMAX)
    `NMD_ASSERT_IMP(a_zero_has_target, i_clk, i_rst_n, r_out_valid && (r_out_dist == '0),
                    !r_out_no_target)
    `NMD_ASSERT_NXT(a_last_ends, i_clk, i_rst_n,
                    r_out_valid && r_out_last && !i_out_stall, !r_out_valid)

endmodule

// File: rtl/nearest_match_distance.sv
// ----------------------------------------------------------------------------
// nearest_match_distance
// Per-position distance to the nearest target byte within a byte string.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_stall    i_text_byte, i_final_byte
//   output    out        o_out_valid / i_out_stall  o_distance, o_no_target,
//                                                   o_truncated, o_last_result
//   config    in         i_cfg_wr_en                i_cfg_wr_data (target byte)
//
// Load takes one beat per cycle. A string of n stored bytes then passes through
// a turnaround state, a backward pass over its n RAM entries (one entry a cycle
// over the single write port), a read-prime state and n result beats at one a
// cycle while the output is not stalled, then returns to load.
// Synchronous active-low reset; the distance RAM is not cleared.
// The input is stalled outside the load phase; an output stall holds emission.
// ----------------------------------------------------------------------------
module nearest_match_distance #(
    parameter int MAX_LEN = nmd_pkg::MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [7:0]                   i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_text_byte,
    input  logic                         i_final_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [$clog2(MAX_LEN+1)-1:0] o_distance,
    output logic                         o_no_target,
    output logic                         o_truncated,
    output logic                         o_last_result
);

    import nmd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    nmd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_final_byte (i_final_byte),
        .o_in_stall   (o_in_stall),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    nmd_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_text_byte   (i_text_byte),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_distance    (o_distance),
        .o_no_target   (o_no_target),
        .o_truncated   (o_truncated),
        .o_last_result (o_last_result)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_match_distance. Strings are fed with random
// gaps and random output stalls. A behavioural tracker builds the expected
// distance beats from every accepted input beat. A checker compares each
// output beat with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_LEN    = nmd_pkg::MAX_LEN_DEF;
    localparam int DW         = $clog2(MAX_LEN + 1);
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 16;
    localparam int RAND_BYTES = 200;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [DW-1:0] distance;
        logic          no_target;
        logic          truncated;
        logic          last_result;
    } dist_beat_t;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_cfg_wr_en   = 1'b0;
    logic [7:0]    i_cfg_wr_data = 8'h00;
    logic          i_in_valid    = 1'b0;
    logic          o_in_stall;
    logic [7:0]    i_text_byte   = 8'h00;
    logic          i_final_byte  = 1'b0;
    logic          o_out_valid;
    logic          i_out_stall   = 1'b0;
    logic [DW-1:0] o_distance;
    logic          o_no_target;
    logic          o_truncated;
    logic          o_last_result;

    nearest_match_distance #(.MAX_LEN(MAX_LEN)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_distance   (o_distance),
        .o_no_target  (o_no_target),
        .o_truncated  (o_truncated),
        .o_last_result(o_last_result)
    );

    // tracker state
    logic [7:0] target_q;
    logic       hit_flag [MAX_LEN];
    int         fwd_dist [MAX_LEN];
    int         stored_cnt;
    logic       dropped_seen;

    dist_beat_t expected_dist_q[$];
    int         mismatch_cnt = 0;
    int         bytes_sent   = 0;
    bit         tx_calm      = 1'b0;
    bit         rx_calm      = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int sat_inc(input int v);
        return (v >= MAX_LEN) ? MAX_LEN : v + 1;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic track_beat(input logic [7:0] b, input logic fin);
        dist_beat_t rec;
        int         bwd [MAX_LEN];
        int         back;
        int         i;
        logic       any_hit;
        if (stored_cnt < MAX_LEN) begin
            hit_flag[stored_cnt] = (b == target_q);
            if (b == target_q)
                fwd_dist[stored_cnt] = 0;
            else if (stored_cnt == 0)
                fwd_dist[stored_cnt] = MAX_LEN;
            else
                fwd_dist[stored_cnt] = sat_inc(fwd_dist[stored_cnt - 1]);
            stored_cnt++;
        end else begin
            dropped_seen = 1'b1;
        end
        if (fin) begin
            any_hit = 1'b0;
            back    = MAX_LEN;
            for (i = stored_cnt - 1; i >= 0; i--) begin
                if (hit_flag[i]) any_hit = 1'b1;
                back   = hit_flag[i] ? 0 : sat_inc(back);
                bwd[i] = back;
            end
            for (i = 0; i < stored_cnt; i++) begin
                rec.distance    = DW'((bwd[i] < fwd_dist[i]) ? bwd[i] : fwd_dist[i]);
                rec.no_target   = !any_hit;
                rec.truncated   = dropped_seen;
                rec.last_result = (i == stored_cnt - 1);
                expected_dist_q.push_back(rec);
            end
            stored_cnt   = 0;
            dropped_seen = 1'b0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_calm ? 0 : gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_text_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        track_beat(b, fin);
        bytes_sent++;
    endtask

    task automatic send_string(input byte_q_t s);
        int i;
        for (i = 0; i < s.size(); i++)
            send_byte(s[i], i == s.size() - 1);
    endtask

    function automatic byte_q_t random_string(input int len, input bit no_hit);
        byte_q_t    s;
        logic [7:0] b;
        int         i;
        for (i = 0; i < len; i++) begin
            if (!no_hit && $urandom_range(0, 3) == 0)
                b = target_q;
            else
                b = 8'($urandom_range(0, 255));
            if (no_hit && b == target_q) b = b ^ 8'h01;
            s.push_back(b);
        end
        return s;
    endfunction

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_dist_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_target(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        target_q = v;
    endtask

    task automatic test_directed();
        send_string('{8'h00});
        send_string('{8'h05});
        send_string('{8'h00, 8'hFF, 8'hFF, 8'h00});
        drain();
        set_target(8'hFF);
        send_string('{8'hFF, 8'h01, 8'h02, 8'h03});
        send_string('{8'h01, 8'h02, 8'h03, 8'hFF});
        send_string('{8'h07, 8'hFF, 8'h09, 8'h09, 8'h09, 8'hFF, 8'h00});
        drain();
    endtask

    task automatic test_full_store();
        byte_q_t s;
        set_target(8'($urandom_range(0, 255)));
        s = random_string(MAX_LEN, 1'b1);
        s[0] = target_q;
        send_string(s);
        drain();
    endtask

    task automatic test_truncation();
        byte_q_t s;
        set_target(8'hA5);
        // only hit lies beyond the store
        s = random_string(MAX_LEN + 2, 1'b1);
        s[MAX_LEN + 1] = target_q;
        send_string(s);
        drain();
    endtask

    task automatic test_random();
        int phase;
        int strings;
        int len;
        int sel;
        phase = 0;
        while (bytes_sent < RAND_BYTES) begin
            case (phase)
                0:       set_target(8'h00);
                1:       set_target(8'hFF);
                default: set_target(8'($urandom_range(0, 255)));
            endcase
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            strings = $urandom_range(2, 5);
            repeat (strings) begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    len = $urandom_range(40, MAX_LEN + 8);
                else if (sel < 4)
                    len = $urandom_range(13, 30);
                else
                    len = $urandom_range(1, 12);
                send_string(random_string(len, $urandom_range(0, 5) == 0));
            end
            drain();
            phase++;
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // output stall pattern
    int stall_left = 0;
    int free_left  = 0;
    always @(negedge i_clk) begin
        if (rx_calm) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            i_out_stall <= 1'b0;
        end else begin
            free_left  = $urandom_range(0, 8);
            stall_left = gap_len();
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        dist_beat_t want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_dist_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: unexpected beat dist=%0d nt=%b tr=%b last=%b", $realtime,
                             o_distance, o_no_target, o_truncated, o_last_result);
            end else begin
                want = expected_dist_q.pop_front();
                if (o_distance !== want.distance || o_no_target !== want.no_target ||
                    o_truncated !== want.truncated || o_last_result !== want.last_result) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: exp d=%0d nt=%b tr=%b l=%b got d=%0d nt=%b tr=%b l=%b",
                                 $realtime, want.distance, want.no_target, want.truncated,
                                 want.last_result, o_distance, o_no_target, o_truncated,
                                 o_last_result);
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired", $realtime);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        target_q     = 8'h00;
        stored_cnt   = 0;
        dropped_seen = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_store();
        test_truncation();
        test_random();
        drain();
        if (mismatch_cnt == 0 && expected_dist_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
